/* design/lfu_cache_with_lru_tiebreak_defines.svh */
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared assertion shorthands for the cache modules.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Defaults, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_BITS       = 5;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

/* design/lfu_cache_with_lru_tiebreak.sv */
// An accepted word is latched, the scan reads one entry a cycle, and the update then
// writes the result word into an output register. A new request is taken only after
// the last one is updated. A result waits in the output register; the next request
// is taken while it waits. Reset (rst_n low, synchronous) clears all entry valid bits
// and age ranks at once and sets cap_r to 16; no clearing pass follows.
// ----------------------------------------------------------------------------
// LFU cache with LRU tiebreak
// Key-value cache with least-frequently-used replacement over a stream port.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lfu_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [63:0]                  in_tdata,  // key [31:0], write_value [63:32]
  input  logic                         in_tuser,  // action
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [63:0]                  out_tdata, // read_value [31:0], evicted_key [63:32]
  output logic [1:0]                   out_tuser  // hit [0], evicted [1]
);

  lfu_pkg::cmd_t cmd;
  lfu_pkg::sts_t sts;
  logic [lfu_pkg::CFG_BITS-1:0] cap_r;
  logic hit, evicted;
  logic [31:0] read_value, evicted_key;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lfu_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cap_cfg         (cap_r),
    .in_action       (in_tuser),
    .in_key          (in_tdata[31:0]),
    .in_wval         (in_tdata[63:32]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_hit         (hit),
    .out_read_value  (read_value),
    .out_evicted     (evicted),
    .out_evicted_key (evicted_key)
  );

  assign out_tdata = {evicted_key, read_value};
  assign out_tuser = {evicted, hit};

endmodule

/* design/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences load, entry scan and update of one request at a time.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lfu_pkg::sts_t sts,
  output lfu_pkg::cmd_t cmd
);

  lfu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = lfu_pkg::ST_UPDATE;
        end
      end
      lfu_pkg::ST_UPDATE: begin
        // Hold the update until the result register can take the word.
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/lfu_dp.sv */
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry storage, sequential entry scan, replacement update, result register.
// ----------------------------------------------------------------------------
`include "lfu_cache_with_lru_tiebreak_defines.svh"

module lfu_dp #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfu_pkg::cmd_t                cmd,
  output lfu_pkg::sts_t                sts,
  input  logic [lfu_pkg::CFG_BITS-1:0] cap_cfg,
  input  logic                         in_action,
  input  logic [31:0]                  in_key,
  input  logic [31:0]                  in_wval,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic                         out_hit,
  output logic [31:0]                  out_read_value,
  output logic                         out_evicted,
  output logic [31:0]                  out_evicted_key
);

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW  = $clog2(CAPACITY + 1);
  localparam int CW  = (OW > lfu_pkg::CFG_BITS) ? OW : lfu_pkg::CFG_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  valid_r [CAPACITY];
  logic [31:0]           key_r   [CAPACITY];
  logic [VALUE_BITS-1:0] value_r [CAPACITY];
  logic [COUNT_BITS-1:0] count_r [CAPACITY];
  logic [IW-1:0]         rank_r  [CAPACITY];
  logic                  valid_nxt [CAPACITY];
  logic [IW-1:0]         rank_nxt  [CAPACITY];

  // Request latched at accept.
  logic                  act_r;
  logic [31:0]           req_key_r;
  logic [VALUE_BITS-1:0] wval_r;

  // Scan results.
  logic [IW-1:0]         idx_r;
  logic [OW-1:0]         occ_r;
  logic                  found_r;
  logic [IW-1:0]         fidx_r;
  logic [VALUE_BITS-1:0] fval_r;
  logic [COUNT_BITS-1:0] fcnt_r;
  logic [IW-1:0]         frank_r;
  logic                  vfound_r;
  logic [IW-1:0]         vidx_r;
  logic [31:0]           vkey_r;
  logic [COUNT_BITS-1:0] vcnt_r;
  logic [IW-1:0]         vrank_r;
  logic                  free_r;
  logic [IW-1:0]         freeidx_r;

  logic                  out_valid_r;
  logic                  hit_r, evicted_r;
  logic [31:0]           read_r, evkey_r;

  logic [CW-1:0] cap_eff;
  logic          neg, do_touch, do_write_found, do_insert, do_evict;
  logic [IW-1:0] slot;
  logic          res_hit, res_ev;
  logic [31:0]   res_read, res_evkey;
  logic [63:0]   fval_wide, wval_wide;

  assign sts.scan_last = (idx_r == LAST_IDX);
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign cap_eff   = (CW'(cap_cfg) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_cfg);
  assign neg       = req_key_r[31];
  assign fval_wide = 64'(fval_r);
  assign wval_wide = 64'(wval_r);

  always_comb begin
    do_touch       = 1'b0;
    do_write_found = 1'b0;
    do_insert      = 1'b0;
    do_evict       = 1'b0;
    res_hit        = 1'b0;
    res_ev         = 1'b0;
    res_read       = '0;
    res_evkey      = '0;
    slot           = freeidx_r;
    if (cap_eff != '0) begin
      if (act_r == lfu_pkg::ACT_GET) begin
        if (!neg && found_r) begin
          do_touch = 1'b1;
          res_hit  = 1'b1;
          res_read = fval_wide[31:0];
        end
      end else if (found_r) begin
        do_write_found = 1'b1;
        do_touch       = !neg;
        res_hit        = 1'b1;
        res_read       = wval_wide[31:0];
      end else begin
        do_insert = 1'b1;
        do_evict  = (CW'(occ_r) >= cap_eff) && vfound_r;
        if (do_evict) begin
          res_ev    = 1'b1;
          res_evkey = vkey_r;
          // The evicted slot becomes the lowest free one unless an earlier slot is free.
          if (!(free_r && freeidx_r < vidx_r)) begin
            slot = vidx_r;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (do_touch) begin
        if (IW'(i) == fidx_r) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && rank_r[i] < frank_r) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      if (do_insert) begin
        if (do_evict && IW'(i) == vidx_r) begin
          valid_nxt[i] = 1'b0;
        end else if (valid_r[i]) begin
          if (do_evict && rank_r[i] > vrank_r) begin
            rank_nxt[i] = rank_r[i];
          end else begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
        if (IW'(i) == slot) begin
          valid_nxt[i] = 1'b1;
          rank_nxt[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_write_found) begin
        value_r[fidx_r] <= wval_r;
      end
      if (do_touch) begin
        count_r[fidx_r] <= (fcnt_r == CNT_MAX) ? fcnt_r : fcnt_r + 1'b1;
      end
      if (do_insert) begin
        key_r[slot]   <= req_key_r;
        value_r[slot] <= wval_r;
        count_r[slot] <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      req_key_r <= in_key;
      wval_r    <= VALUE_BITS'(in_wval);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      occ_r    <= '0;
      found_r  <= 1'b0;
      vfound_r <= 1'b0;
      free_r   <= 1'b0;
    end else if (cmd.load) begin
      idx_r    <= '0;
      occ_r    <= '0;
      found_r  <= 1'b0;
      vfound_r <= 1'b0;
      free_r   <= 1'b0;
    end else if (cmd.scan) begin
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      if (valid_r[idx_r]) begin
        occ_r <= occ_r + 1'b1;
        if (key_r[idx_r] == req_key_r) begin
          found_r <= 1'b1;
        end
        if (!vfound_r || count_r[idx_r] < vcnt_r ||
            (count_r[idx_r] == vcnt_r && rank_r[idx_r] > vrank_r)) begin
          vfound_r <= 1'b1;
        end
      end else begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && valid_r[idx_r]) begin
      if (key_r[idx_r] == req_key_r) begin
        fidx_r  <= idx_r;
        fval_r  <= value_r[idx_r];
        fcnt_r  <= count_r[idx_r];
        frank_r <= rank_r[idx_r];
      end
      if (!vfound_r || count_r[idx_r] < vcnt_r ||
          (count_r[idx_r] == vcnt_r && rank_r[idx_r] > vrank_r)) begin
        vidx_r  <= idx_r;
        vkey_r  <= key_r[idx_r];
        vcnt_r  <= count_r[idx_r];
        vrank_r <= rank_r[idx_r];
      end
    end
    if (cmd.scan && !valid_r[idx_r] && !free_r) begin
      freeidx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= res_hit;
      read_r    <= res_read;
      evicted_r <= res_ev;
      evkey_r   <= res_evkey;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_hit         = hit_r;
  assign out_read_value  = read_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evkey_r;

  `LFU_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_r, "result missing after update")
  `LFU_ASSERT_NOW(a_ev_not_hit, out_valid_r && evicted_r, !hit_r, "eviction on a hit")
  `LFU_ASSERT_NEXT(a_load_rewinds, cmd.load, idx_r == '0 && !found_r, "scan not restarted")

endmodule

/* sim/lfu_cache_checker.sv */
// ----------------------------------------------------------------------------
// LFU cache result checker
// Watches the request, result and capacity channels, keeps a software image of
// the cache entries and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module lfu_cache_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = lfu_pkg::CAPACITY_DEF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_t;

  lookup_t     lookup_q[$];
  logic        slot_used[NENT];
  logic [31:0] slot_key[NENT];
  logic [31:0] slot_val[NENT];
  logic [15:0] slot_uses[NENT];
  logic [3:0]  slot_age[NENT];
  logic [4:0]  cap_reg;

  assign pending_count = lookup_q.size();

  // Moves an entry to the front and bumps its use count.
  function automatic void promote(int e);
    for (int i = 0; i < NENT; i++)
      if (slot_used[i] && i != e && slot_age[i] < slot_age[e]) slot_age[i]++;
    slot_age[e] = 0;
    if (slot_uses[e] != COUNT_MAX) slot_uses[e]++;
  endfunction

  function automatic lookup_t cache_access(logic act, logic [31:0] key, logic [31:0] wval);
    lookup_t r;
    int cap, found, occ, v;
    r = '0;
    found = -1;
    occ = 0;
    v = -1;
    cap = (cap_reg > NENT) ? NENT : cap_reg;
    if (cap == 0) return r;
    for (int i = 0; i < NENT; i++)
      if (slot_used[i]) begin
        occ++;
        if (slot_key[i] == key) found = i;
      end
    if (act == lfu_pkg::ACT_GET) begin
      if (key[31] || found < 0) return r;
      promote(found);
      r.hit = 1'b1;
      r.read_value = slot_val[found];
      return r;
    end
    if (found >= 0) begin
      slot_val[found] = wval;
      if (!key[31]) promote(found);
      r.hit = 1'b1;
      r.read_value = wval;
      return r;
    end
    if (occ >= cap) begin
      for (int i = 0; i < NENT; i++)
        if (slot_used[i] && (v < 0 || slot_uses[i] < slot_uses[v] ||
            (slot_uses[i] == slot_uses[v] && slot_age[i] > slot_age[v]))) v = i;
      if (v >= 0) begin
        slot_used[v] = 1'b0;
        for (int i = 0; i < NENT; i++)
          if (slot_used[i] && slot_age[i] > slot_age[v]) slot_age[i]--;
        r.evicted = 1'b1;
        r.evicted_key = slot_key[v];
      end
    end
    for (int i = 0; i < NENT; i++)
      if (!slot_used[i]) begin
        for (int j = 0; j < NENT; j++) if (slot_used[j]) slot_age[j]++;
        slot_used[i] = 1'b1;
        slot_key[i] = key;
        slot_val[i] = wval;
        slot_uses[i] = 16'd1;
        slot_age[i] = '0;
        break;
      end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = '0;
      end
      cap_reg = lfu_pkg::CFG_RESET;
      lookup_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (out_tvalid && out_tready) begin
        got = {out_tuser[0], out_tdata[31:0], out_tuser[1], out_tdata[63:32]};
        if (lookup_q.size() == 0) begin
          $display("%0t: unexpected result word, actual %h", $time, got);
          fail_count++;
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            $display("%0t: result mismatch, expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        lookup_q.push_back(cache_access(in_tuser, in_tdata[31:0], in_tdata[63:32]));
    end
  end
endmodule

/* sim/tb_lfu_cache_with_lru_tiebreak.sv */
// ----------------------------------------------------------------------------
// LFU cache testbench
// Drives directed and random get/put traffic with random gaps and stalls over
// several capacity settings; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_lfu_cache_with_lru_tiebreak;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;  // key [31:0], write_value [63:32]
  logic        in_tuser = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // read_value [31:0], evicted_key [63:32]
  logic [1:0]  out_tuser;  // hit [0], evicted [1]
  int          fail_count;
  int          pending_count;
  int          cycles = 0;
  bit          long_hold = 1'b0;
  logic [31:0] key_pool[8];

  always #5 clk = ~clk;

  lfu_cache_with_lru_tiebreak DUT (.*);
  lfu_cache_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off while the sender keeps going.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        if (out_tready) out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Leaves in_tvalid high after the accepting edge; the next call or the caller drops it.
  task automatic send_word(logic act, logic [31:0] key, logic [31:0] wval, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {wval, key};
    @(posedge clk iff in_tready);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    in_tvalid <= 1'b0;
    @(posedge clk iff pending_count == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n, int key_span);
    logic [31:0] key, wval;
    logic act;
    bit fast;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: key = $urandom();
        1: key = key_pool[$urandom_range(0, 7)] | 32'h8000_0000;
        default: key = $urandom_range(0, key_span);
      endcase
      act = $urandom_range(0, 2) != 0 ? lfu_pkg::ACT_GET : lfu_pkg::ACT_PUT;
      if ($urandom_range(0, 1)) act = lfu_pkg::ACT_PUT;
      wval = $urandom();
      fast = (k % 100) > 70;
      send_word(act, key, wval, fast);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys and values, misses, updates, negative keys.
    send_word(lfu_pkg::ACT_GET, 32'd5, 32'd0, 0);
    send_word(lfu_pkg::ACT_PUT, 32'd0, 32'hFFFF_FFFF, 0);
    send_word(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h0, 0);
    send_word(lfu_pkg::ACT_PUT, 32'h8000_0000, 32'hA5A5_5A5A, 0);
    send_word(lfu_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 0);
    send_word(lfu_pkg::ACT_GET, 32'h8000_0000, 32'h0, 0);
    send_word(lfu_pkg::ACT_PUT, 32'h8000_0000, 32'h5A5A_A5A5, 0);
    send_word(lfu_pkg::ACT_GET, 32'h0, 32'hFFFF_FFFF, 0);
    send_word(lfu_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0, 0);
    send_word(lfu_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h5555_AAAA, 0);
    for (int i = 1; i <= 14; i++)
      send_word(lfu_pkg::ACT_PUT, i, ~i, 1);

    // Full cache at reset capacity; the receiver holds off for a while.
    long_hold = 1'b1;
    random_phase(300, 24);

    // Sender waits for every result, then lowers capacity below occupancy.
    write_capacity(5'd3);
    random_phase(200, 8);
    write_capacity(5'd0);
    random_phase(60, 8);
    write_capacity(5'd31);
    random_phase(250, 40);
    write_capacity(5'd1);
    random_phase(150, 4);
    write_capacity(5'd16);
    random_phase(250, 20);
    write_capacity(5'd7);
    random_phase(220, 12);

    in_tvalid <= 1'b0;
    @(posedge clk iff pending_count == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/lfu_pkg.sv
design/lfu_ctrl.sv
design/lfu_dp.sv
design/lfu_cache_with_lru_tiebreak.sv
sim/lfu_cache_checker.sv
sim/tb_lfu_cache_with_lru_tiebreak.sv
